/* src/radar_measurement_jacobian_assert.svh */
// Assertion helpers for the radar Jacobian block.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef RADAR_MEASUREMENT_JACOBIAN_ASSERT_SVH
`define RADAR_MEASUREMENT_JACOBIAN_ASSERT_SVH

// Same-cycle implication.
`define RMJ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmj assertion failed (same cycle)");

// Next-cycle implication.
`define RMJ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmj assertion failed (next cycle)");

`endif

/* src/rmj_pkg.sv */
package rmj_pkg;

  // word width of every input field and derivative
  localparam int DataWidth       = 32;
  localparam int FracBitsDefault = 16;

  // threshold register
  localparam int                  CfgWidth   = 17;
  localparam logic [CfgWidth-1:0] MinR2Reset = CfgWidth'(7);

  typedef struct packed {
    logic signed [DataWidth-1:0] pos_x;
    logic signed [DataWidth-1:0] pos_y;
    logic signed [DataWidth-1:0] vel_x;
    logic signed [DataWidth-1:0] vel_y;
  } rmj_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] drange_dx;
    logic signed [DataWidth-1:0] drange_dy;
    logic signed [DataWidth-1:0] dbearing_dx;
    logic signed [DataWidth-1:0] dbearing_dy;
    logic signed [DataWidth-1:0] drate_dx;
    logic signed [DataWidth-1:0] drate_dy;
    logic                        near_origin;
  } rmj_out_t;

endpackage

/* src/rmj_sqrt.sv */
// Pipelined integer square root, one root bit per stage, floor result.
module rmj_sqrt
  import rmj_pkg::*;
#(
  parameter int RW = DataWidth
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW-1:0]   root_o
);

  localparam int IW = 2 * RW;

  // remainder can reach 2*root, so it needs one bit more than the root
  logic [RW:0]   rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [IW-1:0] rad_q  [RW];

  logic [RW:0]   rem_in  [RW];
  logic [RW-1:0] root_in [RW];
  logic [IW-1:0] rad_in  [RW];
  logic [RW+2:0] rem_sh  [RW];
  logic [RW+2:0] trial   [RW];
  logic          ge      [RW];

  // stage inputs: first stage from the port, others from the previous stage
  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = rad_i;
    for (int k = 1; k < RW; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      rad_in[k]  = rad_q[k-1];
    end
  end

  // bring down two radicand bits, try root*4+1
  always_comb begin
    for (int k = 0; k < RW; k++) begin
      rem_sh[k] = {rem_in[k], rad_in[k][IW-1 -: 2]};
      trial[k]  = {1'b0, root_in[k], 2'b01};
      ge[k]     = rem_sh[k] >= trial[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < RW; k++) begin
        rem_q[k]  <= ge[k] ? (RW+1)'(rem_sh[k] - trial[k]) : (RW+1)'(rem_sh[k]);
        root_q[k] <= {root_in[k][RW-2:0], ge[k]};
        rad_q[k]  <= {rad_in[k][IW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

/* src/rmj_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// over_o flags a quotient that does not fit in QW bits.
module rmj_div
  import rmj_pkg::*;
#(
  parameter int NW = 2 * DataWidth,
  parameter int DW = DataWidth,
  parameter int QW = DataWidth
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          over_o
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] nlo_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic          over_q [QW+1];

  logic [DW:0]   rem_sh [QW+1];
  logic [DW:0]   dif    [QW+1];
  logic          ge     [QW+1];

  // quotient fits in QW bits iff num >> QW is below the divisor
  assign hi_ext  = CW'(num_i[NW-1:QW]);
  assign den_ext = CW'(den_i);

  // shift in one numerator bit, subtract when it fits
  always_comb begin
    rem_sh[0] = '0;
    dif[0]    = '0;
    ge[0]     = 1'b0;
    for (int k = 1; k <= QW; k++) begin
      rem_sh[k] = {rem_q[k-1], nlo_q[k-1][QW-1]};
      dif[k]    = rem_sh[k] - {1'b0, den_q[k-1]};
      ge[k]     = rem_sh[k] >= {1'b0, den_q[k-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DW'(num_i[NW-1:QW]);
      nlo_q[0]  <= num_i[QW-1:0];
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      over_q[0] <= hi_ext >= den_ext;
      for (int k = 1; k <= QW; k++) begin
        rem_q[k]  <= ge[k] ? dif[k][DW-1:0] : rem_sh[k][DW-1:0];
        nlo_q[k]  <= {nlo_q[k-1][QW-2:0], 1'b0};
        den_q[k]  <= den_q[k-1];
        quo_q[k]  <= {quo_q[k-1][QW-2:0], ge[k]};
        over_q[k] <= over_q[k-1];
      end
    end
  end

  assign quo_o  = quo_q[QW];
  assign over_o = over_q[QW];

endmodule

/* src/radar_measurement_jacobian.sv */
// Radar measurement Jacobian for a constant-velocity state.
// Input channel: in_valid_i / in_stall_o carry one word (pos_x, pos_y,
// vel_x, vel_y, signed fixed point with FRAC_BITS fraction bits).
// Output channel: out_valid_o / out_stall_i carry one word of six partial
// derivatives plus near_origin. A word moves when valid is high and stall
// is low. Threshold on x*x+y*y is written through cfg_we_i / cfg_wdata_i.
// Throughput: one word per cycle while the output word is not stalled.
// A word passes the sign, product and r2 stages, the square root (one
// root bit per stage), the multiply and add stages, the dividers (one
// quotient bit per stage plus an overflow check stage) and out_q.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the
// threshold to 7. While the output word is stalled the whole pipeline
// holds and in_stall_o is high; nothing is dropped or repeated.
// Below the threshold all derivatives are zero and near_origin is set.
module radar_measurement_jacobian
  import rmj_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rmj_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rmj_out_t            out_data_o
);

  localparam int W      = DataWidth;
  localparam int F      = FRAC_BITS;
  localparam int NumDiv = 6;

  typedef struct packed {
    logic [W-1:0]      ax;
    logic [W-1:0]      ay;
    logic [2*W-1:0]    r2;
    logic [2*W-1:0]    cm;
    logic [NumDiv-1:0] neg;
  } sq_side_t;

  typedef struct packed {
    logic [NumDiv-1:0] neg;
    logic              kill;
    logic              near;
  } dv_side_t;

  function automatic logic [W-1:0] sat_mag(input logic [W-1:0] quo, input logic over,
                                           input logic neg);
    logic [W-1:0] lim;
    logic [W-1:0] mag;
    lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    mag = (over || quo > lim) ? lim : quo;
    return neg ? (~mag + W'(1)) : mag;
  endfunction

  logic                en;
  logic [CfgWidth-1:0] min_r2_q;

  logic         s1_valid_q;
  logic [3:0]   s1_sgn_q;
  logic [W-1:0] s1_mag_q [4];
  logic [W-1:0] in_raw   [4];

  logic           s2_valid_q;
  logic [3:0]     s2_sgn_q;
  logic [W-1:0]   s2_ax_q, s2_ay_q;
  logic [2*W-1:0] s2_xx_q, s2_yy_q, s2_p1_q, s2_p2_q;

  logic           s3_valid_q;
  sq_side_t       s3_side_q;
  sq_side_t       s3_side_d;
  logic           sgn_p1, sgn_p2, sgn_c;

  logic     sq_valid_q [W];
  sq_side_t sq_side_q  [W];
  logic [W-1:0] root;

  logic           m_valid_q;
  logic [2*W-1:0] m_r3lo_q, m_r3hi_q, m_nylo_q, m_nyhi_q, m_nxlo_q, m_nxhi_q;
  logic [W-1:0]   m_root_q, m_ax_q, m_ay_q;
  logic [2*W-1:0] m_r2_q;
  dv_side_t       m_dv_q;
  dv_side_t       m_dv_d;

  logic           a_valid_q;
  logic [3*W-1:0] a_r3_q, a_ny_q, a_nx_q;
  logic [W-1:0]   a_root_q, a_ax_q, a_ay_q;
  logic [2*W-1:0] a_r2_q;
  dv_side_t       a_dv_q;

  logic         dv_valid_q [W+1];
  dv_side_t     dv_side_q  [W+1];
  logic [W-1:0] dv_quo     [NumDiv];
  logic         dv_over    [NumDiv];

  logic     out_valid_q;
  rmj_out_t out_q;
  rmj_out_t out_d;

  // whole pipeline advances unless the output word is stalled
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_r2_q <= MinR2Reset;
    end else if (cfg_we_i) begin
      min_r2_q <= cfg_wdata_i;
    end
  end

  // valid bits of every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      m_valid_q   <= 1'b0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < W; k++) sq_valid_q[k] <= 1'b0;
      for (int k = 0; k <= W; k++) dv_valid_q[k] <= 1'b0;
    end else if (en) begin
      s1_valid_q    <= in_valid_i;
      s2_valid_q    <= s1_valid_q;
      s3_valid_q    <= s2_valid_q;
      sq_valid_q[0] <= s3_valid_q;
      for (int k = 1; k < W; k++) sq_valid_q[k] <= sq_valid_q[k-1];
      m_valid_q     <= sq_valid_q[W-1];
      a_valid_q     <= m_valid_q;
      dv_valid_q[0] <= a_valid_q;
      for (int k = 1; k <= W; k++) dv_valid_q[k] <= dv_valid_q[k-1];
      out_valid_q   <= dv_valid_q[W];
    end
  end

  // stage 1: sign and magnitude (x, y, vx, vy)
  assign in_raw[0] = in_data_i.pos_x;
  assign in_raw[1] = in_data_i.pos_y;
  assign in_raw[2] = in_data_i.vel_x;
  assign in_raw[3] = in_data_i.vel_y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_sgn_q[i] <= in_raw[i][W-1];
        s1_mag_q[i] <= in_raw[i][W-1] ? (~in_raw[i] + W'(1)) : in_raw[i];
      end
    end
  end

  // stage 2: squares and cross products
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sgn_q <= s1_sgn_q;
      s2_ax_q  <= s1_mag_q[0];
      s2_ay_q  <= s1_mag_q[1];
      s2_xx_q  <= (2*W)'(s1_mag_q[0]) * (2*W)'(s1_mag_q[0]);
      s2_yy_q  <= (2*W)'(s1_mag_q[1]) * (2*W)'(s1_mag_q[1]);
      s2_p1_q  <= (2*W)'(s1_mag_q[2]) * (2*W)'(s1_mag_q[1]);
      s2_p2_q  <= (2*W)'(s1_mag_q[3]) * (2*W)'(s1_mag_q[0]);
    end
  end

  // stage 3: r2 and signed cross term vx*y - vy*x
  assign sgn_p1 = s2_sgn_q[2] ^ s2_sgn_q[1];
  assign sgn_p2 = !(s2_sgn_q[3] ^ s2_sgn_q[0]);

  always_comb begin
    s3_side_d.ax = s2_ax_q;
    s3_side_d.ay = s2_ay_q;
    s3_side_d.r2 = s2_xx_q + s2_yy_q;
    if (sgn_p1 == sgn_p2) begin
      s3_side_d.cm = s2_p1_q + s2_p2_q;
      sgn_c        = sgn_p1;
    end else if (s2_p1_q >= s2_p2_q) begin
      s3_side_d.cm = s2_p1_q - s2_p2_q;
      sgn_c        = sgn_p1;
    end else begin
      s3_side_d.cm = s2_p2_q - s2_p1_q;
      sgn_c        = sgn_p2;
    end
    // result signs in output order
    s3_side_d.neg = {s2_sgn_q[0] ^ !sgn_c, s2_sgn_q[1] ^ sgn_c, s2_sgn_q[0],
                     !s2_sgn_q[1], s2_sgn_q[1], s2_sgn_q[0]};
  end

  always_ff @(posedge clk_i) begin
    if (en) s3_side_q <= s3_side_d;
  end

  // square root, side data delayed alongside
  rmj_sqrt #(
    .RW(W)
  ) u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (s3_side_q.r2),
    .root_o(root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_side_q[0] <= s3_side_q;
      for (int k = 1; k < W; k++) sq_side_q[k] <= sq_side_q[k-1];
    end
  end

  // multiply stage: partial products of r^3 and the two rate numerators
  always_comb begin
    m_dv_d.neg  = sq_side_q[W-1].neg;
    m_dv_d.near = sq_side_q[W-1].r2 < (2*W)'({min_r2_q, {F{1'b0}}});
    m_dv_d.kill = m_dv_d.near || (sq_side_q[W-1].r2 == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_r3lo_q <= (2*W)'(sq_side_q[W-1].r2[W-1:0]) * (2*W)'(root);
      m_r3hi_q <= (2*W)'(sq_side_q[W-1].r2[2*W-1:W]) * (2*W)'(root);
      m_nylo_q <= (2*W)'(sq_side_q[W-1].ay) * (2*W)'(sq_side_q[W-1].cm[W-1:0]);
      m_nyhi_q <= (2*W)'(sq_side_q[W-1].ay) * (2*W)'(sq_side_q[W-1].cm[2*W-1:W]);
      m_nxlo_q <= (2*W)'(sq_side_q[W-1].ax) * (2*W)'(sq_side_q[W-1].cm[W-1:0]);
      m_nxhi_q <= (2*W)'(sq_side_q[W-1].ax) * (2*W)'(sq_side_q[W-1].cm[2*W-1:W]);
      m_root_q <= root;
      m_r2_q   <= sq_side_q[W-1].r2;
      m_ax_q   <= sq_side_q[W-1].ax;
      m_ay_q   <= sq_side_q[W-1].ay;
      m_dv_q   <= m_dv_d;
    end
  end

  // add stage: combine partial products
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_r3_q   <= ((3*W)'(m_r3hi_q) << W) + (3*W)'(m_r3lo_q);
      a_ny_q   <= ((3*W)'(m_nyhi_q) << W) + (3*W)'(m_nylo_q);
      a_nx_q   <= ((3*W)'(m_nxhi_q) << W) + (3*W)'(m_nxlo_q);
      a_root_q <= m_root_q;
      a_r2_q   <= m_r2_q;
      a_ax_q   <= m_ax_q;
      a_ay_q   <= m_ay_q;
      a_dv_q   <= m_dv_q;
    end
  end

  // dividers: x/r, y/r, y/r2, x/r2, ny/r3, nx/r3
  rmj_div #(.NW(W + F), .DW(W), .QW(W)) u_div_rx (
    .clk_i(clk_i), .en_i(en), .num_i({a_ax_q, {F{1'b0}}}), .den_i(a_root_q),
    .quo_o(dv_quo[0]), .over_o(dv_over[0])
  );

  rmj_div #(.NW(W + F), .DW(W), .QW(W)) u_div_ry (
    .clk_i(clk_i), .en_i(en), .num_i({a_ay_q, {F{1'b0}}}), .den_i(a_root_q),
    .quo_o(dv_quo[1]), .over_o(dv_over[1])
  );

  rmj_div #(.NW(W + 2*F), .DW(2*W), .QW(W)) u_div_by (
    .clk_i(clk_i), .en_i(en), .num_i({a_ay_q, {(2*F){1'b0}}}), .den_i(a_r2_q),
    .quo_o(dv_quo[2]), .over_o(dv_over[2])
  );

  rmj_div #(.NW(W + 2*F), .DW(2*W), .QW(W)) u_div_bx (
    .clk_i(clk_i), .en_i(en), .num_i({a_ax_q, {(2*F){1'b0}}}), .den_i(a_r2_q),
    .quo_o(dv_quo[3]), .over_o(dv_over[3])
  );

  rmj_div #(.NW(3*W + F), .DW(3*W), .QW(W)) u_div_vy (
    .clk_i(clk_i), .en_i(en), .num_i({a_ny_q, {F{1'b0}}}), .den_i(a_r3_q),
    .quo_o(dv_quo[4]), .over_o(dv_over[4])
  );

  rmj_div #(.NW(3*W + F), .DW(3*W), .QW(W)) u_div_vx (
    .clk_i(clk_i), .en_i(en), .num_i({a_nx_q, {F{1'b0}}}), .den_i(a_r3_q),
    .quo_o(dv_quo[5]), .over_o(dv_over[5])
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_side_q[0] <= a_dv_q;
      for (int k = 1; k <= W; k++) dv_side_q[k] <= dv_side_q[k-1];
    end
  end

  // saturate, apply sign, zero when refused
  always_comb begin
    out_d.drange_dx   = dv_side_q[W].kill ? '0 :
                        sat_mag(dv_quo[0], dv_over[0], dv_side_q[W].neg[0]);
    out_d.drange_dy   = dv_side_q[W].kill ? '0 :
                        sat_mag(dv_quo[1], dv_over[1], dv_side_q[W].neg[1]);
    out_d.dbearing_dx = dv_side_q[W].kill ? '0 :
                        sat_mag(dv_quo[2], dv_over[2], dv_side_q[W].neg[2]);
    out_d.dbearing_dy = dv_side_q[W].kill ? '0 :
                        sat_mag(dv_quo[3], dv_over[3], dv_side_q[W].neg[3]);
    out_d.drate_dx    = dv_side_q[W].kill ? '0 :
                        sat_mag(dv_quo[4], dv_over[4], dv_side_q[W].neg[4]);
    out_d.drate_dy    = dv_side_q[W].kill ? '0 :
                        sat_mag(dv_quo[5], dv_over[5], dv_side_q[W].neg[5]);
    out_d.near_origin = dv_side_q[W].near;
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "radar_measurement_jacobian_assert.svh"

  `RMJ_ASSERT_IMP(a_stall_back, out_valid_o && out_stall_i, in_stall_o)
  `RMJ_ASSERT_NXT(a_accept_s1, in_valid_i && !in_stall_o, s1_valid_q)
  `RMJ_ASSERT_NXT(a_cfg_write, cfg_we_i, min_r2_q == $past(cfg_wdata_i))
  `RMJ_ASSERT_IMP(a_near_zero, out_valid_o && out_data_o.near_origin, (out_data_o.drange_dx == '0) && (out_data_o.drange_dy == '0) && (out_data_o.dbearing_dx == '0) && (out_data_o.dbearing_dy == '0) && (out_data_o.drate_dx == '0) && (out_data_o.drate_dy == '0))

endmodule
